// ----- rtl/mme_pkg.sv -----
// shared types, constants and helpers for the matrix multiply engine
// no dependencies
package mme_pkg;

  localparam int unsigned DEF_MAX_DIM = 8;

  localparam int unsigned ELEM_W = 16;
  localparam int unsigned PROD_W = 32;
  localparam int unsigned ACC_W  = 35;
  localparam int unsigned POS_W  = 3;
  localparam int unsigned DIM_W  = 4;
  localparam int unsigned CFG_IDX_W = 2;

  // request codes
  localparam logic [1:0] REQ_WRITE_A = 2'd0;
  localparam logic [1:0] REQ_WRITE_B = 2'd1;
  localparam logic [1:0] REQ_COMPUTE = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_B    = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic             rd_en;
    logic             first;
    logic             push;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } mme_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } mme_status_t;

  // last valid index of a dimension: zero counts as one, large values saturate
  function automatic logic [DIM_W-1:0] clamp_last(logic [DIM_W-1:0] v,
                                                  logic [DIM_W-1:0] max_dim);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = '0;
    end else if (v > max_dim) begin
      r = max_dim - 1'b1;
    end else begin
      r = v - 1'b1;
    end
    return r;
  endfunction

endpackage

// ----- rtl/mme_ctrl.sv -----
// controller: dimension registers, loop counters and sequencing state machine
// depends on mme_pkg
module mme_ctrl import mme_pkg::*; #(
  parameter int unsigned MAX_DIM = DEF_MAX_DIM
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [DIM_W-1:0]     cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           req_type_i,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] a_addr_o,
  output logic [$clog2(MAX_DIM*MAX_DIM)-1:0] b_addr_o,
  output mme_cmd_t             cmd_o,
  input  mme_status_t          status_i
);

  localparam int unsigned IDX_W  = $clog2(MAX_DIM);
  localparam int unsigned ADDR_W = $clog2(MAX_DIM*MAX_DIM);
  localparam logic [DIM_W-1:0] MAX_DIM_V = DIM_W'(MAX_DIM);
  localparam logic [IDX_W-1:0] LAST_RST  = IDX_W'(MAX_DIM - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]       state_q, state_d;
  logic [IDX_W-1:0] n_last_q, m_last_q, k_last_q;
  logic [IDX_W-1:0] i_q, i_d, j_q, j_d, t_q, t_d;
  logic [DIM_W-1:0] cfg_last;
  logic             accept;
  logic             elem_last;

  assign cfg_last = clamp_last(cfg_data_i, MAX_DIM_V);

  // dimension registers hold the last index after clamping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_last_q <= LAST_RST;
      m_last_q <= LAST_RST;
      k_last_q <= LAST_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_ROWS_A:    n_last_q <= cfg_last[IDX_W-1:0];
        CFG_INNER_DIM: m_last_q <= cfg_last[IDX_W-1:0];
        CFG_COLS_B:    k_last_q <= cfg_last[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign elem_last  = (i_q == n_last_q) && (j_q == k_last_q);

  assign a_addr_o = ADDR_W'(ADDR_W'(i_q) * ADDR_W'(MAX_DIM) + ADDR_W'(t_q));
  assign b_addr_o = ADDR_W'(ADDR_W'(t_q) * ADDR_W'(MAX_DIM) + ADDR_W'(j_q));

  always_comb begin
    state_d = state_q;
    i_d     = i_q;
    j_d     = j_q;
    t_d     = t_q;
    cmd_o       = '0;
    cmd_o.row   = POS_W'(i_q);
    cmd_o.col   = POS_W'(j_q);
    cmd_o.last  = elem_last;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (req_type_i)
            REQ_WRITE_A: cmd_o.wr_a = 1'b1;
            REQ_WRITE_B: cmd_o.wr_b = 1'b1;
            REQ_COMPUTE: begin
              i_d     = '0;
              j_d     = '0;
              t_d     = '0;
              state_d = ST_RUN;
            end
            default: ;
          endcase
        end
      end
      ST_RUN: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.first = (t_q == '0);
        if (t_q == m_last_q) begin
          t_d     = '0;
          state_d = ST_DRAIN;
        end else begin
          t_d = t_q + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy && status_i.out_free) begin
          cmd_o.push = 1'b1;
          if (elem_last) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_RUN;
            if (j_q == k_last_q) begin
              j_d = '0;
              i_d = i_q + 1'b1;
            end else begin
              j_d = j_q + 1'b1;
            end
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      i_q     <= '0;
      j_q     <= '0;
      t_q     <= '0;
    end else begin
      state_q <= state_d;
      i_q     <= i_d;
      j_q     <= j_d;
      t_q     <= t_d;
    end
  end

  a_push_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.push |-> (!status_i.pipe_busy && status_i.out_free))
    else $error("result pushed before pipeline drained or output free");

  a_last_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.push && cmd_o.last) |=> (state_q == ST_IDLE))
    else $error("final word did not end the compute");

  a_run_leaves_to_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |=> (state_q == ST_RUN || state_q == ST_DRAIN))
    else $error("dot product issue interrupted");

endmodule

// ----- rtl/mme_dp.sv -----
// datapath: element stores, multiply-accumulate pipeline and output register
// depends on mme_pkg
module mme_dp import mme_pkg::*; #(
  parameter int unsigned MAX_DIM = DEF_MAX_DIM
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [POS_W-1:0]         row_index_i,
  input  logic [POS_W-1:0]         col_index_i,
  input  logic signed [ELEM_W-1:0] element_value_i,
  input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0] a_addr_i,
  input  logic [$clog2(MAX_DIM*MAX_DIM)-1:0] b_addr_i,
  input  mme_cmd_t                 cmd_i,
  output mme_status_t              status_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [POS_W-1:0]         out_row_o,
  output logic [POS_W-1:0]         out_col_o,
  output logic signed [ACC_W-1:0]  product_value_o,
  output logic                     last_o
);

  localparam int unsigned IDX_W  = $clog2(MAX_DIM);
  localparam int unsigned DEPTH  = MAX_DIM * MAX_DIM;
  localparam int unsigned ADDR_W = $clog2(DEPTH);

  logic [ELEM_W-1:0] a_mem [DEPTH];
  logic [ELEM_W-1:0] b_mem [DEPTH];

  logic                     in_range;
  logic [ADDR_W-1:0]        wr_addr;
  logic signed [ELEM_W-1:0] a_rd_q, b_rd_q;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [ACC_W-1:0]  acc_q, prod_ext;
  logic                     s1_vld_q, s1_first_q, s2_vld_q, s2_first_q;
  logic                     out_vld_q;
  logic [POS_W-1:0]         out_row_q, out_col_q;
  logic                     out_last_q;
  logic signed [ACC_W-1:0]  out_value_q;

  // out-of-range positions are dropped
  assign in_range = ({1'b0, row_index_i} < DIM_W'(MAX_DIM)) &&
                    ({1'b0, col_index_i} < DIM_W'(MAX_DIM));
  assign wr_addr  = ADDR_W'(ADDR_W'(row_index_i[IDX_W-1:0]) * ADDR_W'(MAX_DIM)
                            + ADDR_W'(col_index_i[IDX_W-1:0]));

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_a && in_range) begin
      a_mem[wr_addr] <= element_value_i;
    end
    if (cmd_i.wr_b && in_range) begin
      b_mem[wr_addr] <= element_value_i;
    end
    if (cmd_i.rd_en) begin
      a_rd_q <= a_mem[a_addr_i];
      b_rd_q <= b_mem[b_addr_i];
    end
  end

  assign prod_ext = ACC_W'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q   <= 1'b0;
      s1_first_q <= 1'b0;
      s2_vld_q   <= 1'b0;
      s2_first_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      s1_vld_q   <= cmd_i.rd_en;
      s1_first_q <= cmd_i.first;
      s2_vld_q   <= s1_vld_q;
      s2_first_q <= s1_first_q;
      if (cmd_i.push) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      prod_q <= a_rd_q * b_rd_q;
    end
    if (s2_vld_q) begin
      acc_q <= s2_first_q ? prod_ext : ACC_W'(acc_q + prod_ext);
    end
    if (cmd_i.push) begin
      out_row_q   <= cmd_i.row;
      out_col_q   <= cmd_i.col;
      out_last_q  <= cmd_i.last;
      out_value_q <= acc_q;
    end
  end

  assign status_o.pipe_busy = s1_vld_q || s2_vld_q;
  assign status_o.out_free  = !out_vld_q || !out_stall_i;

  assign out_valid_o     = out_vld_q;
  assign out_row_o       = out_row_q;
  assign out_col_o       = out_col_q;
  assign product_value_o = out_value_q;
  assign last_o          = out_last_q;

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.rd_en |-> !(cmd_i.wr_a || cmd_i.wr_b))
    else $error("store written during a dot product");

  a_push_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> !(s1_vld_q || s2_vld_q))
    else $error("accumulator taken while products in flight");

  a_first_starts_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s2_vld_q && !$past(s2_vld_q)) |-> s2_first_q)
    else $error("dot product started without clearing the sum");

endmodule

// ----- rtl/matrix_multiply_engine_top.sv -----
// matrix multiply engine: a load word writes one in-range store element; a compute
// word gives rows_a * cols_b result words, each from one store read per cycle over
// inner_dim, then the read, multiply and accumulate stages drain and the word waits
// for a free output register; the single multiply-accumulate unit and one read
// port per store set the rate. async active-low reset clears control and sets all
// dimensions to MAX_DIM; element stores are not cleared and hold junk until written
module matrix_multiply_engine_top import mme_pkg::*; #(
  parameter int unsigned MAX_DIM = DEF_MAX_DIM
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration writes
  input  logic                     cfg_we_i,
  input  logic [CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [DIM_W-1:0]         cfg_data_i,
  // input words
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               req_type_i,
  input  logic [POS_W-1:0]         row_index_i,
  input  logic [POS_W-1:0]         col_index_i,
  input  logic signed [ELEM_W-1:0] element_value_i,
  // result words
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [POS_W-1:0]         out_row_o,
  output logic [POS_W-1:0]         out_col_o,
  output logic signed [ACC_W-1:0]  product_value_o,
  output logic                     last_o
);

  localparam int unsigned ADDR_W = $clog2(MAX_DIM*MAX_DIM);

  // read addresses for the two stores, walked by the controller counters
  logic [ADDR_W-1:0] a_addr;
  logic [ADDR_W-1:0] b_addr;
  mme_cmd_t          cmd;
  mme_status_t       status;

  // sequencing: accepts words only when idle, issues one read pair per cycle in RUN
  mme_ctrl #(
    .MAX_DIM (MAX_DIM)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .req_type_i  (req_type_i),
    .a_addr_o    (a_addr),
    .b_addr_o    (b_addr),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // stores, multiply-accumulate and the output register that decouples stalls
  mme_dp #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .row_index_i     (row_index_i),
    .col_index_i     (col_index_i),
    .element_value_i (element_value_i),
    .a_addr_i        (a_addr),
    .b_addr_i        (b_addr),
    .cmd_i           (cmd),
    .status_o        (status),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_row_o       (out_row_o),
    .out_col_o       (out_col_o),
    .product_value_o (product_value_o),
    .last_o          (last_o)
  );

endmodule
